### src/expert_usage_decay_tracker_core_assert.svh
// Assertion macros shared by the decay tracker RTL.
`ifndef EXPERT_USAGE_DECAY_TRACKER_CORE_ASSERT_SVH
`define EXPERT_USAGE_DECAY_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EUDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion lbl failed");
`define EUDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion lbl failed");
`else
`define EUDT_ASSERT_IMP(lbl, ante, cons)
`define EUDT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/eudt_pkg.sv
// Types, constants and the power table of the expert usage decay tracker.
`timescale 1ns / 1ps
package eudt_pkg;

  localparam int LAYER_W   = 6;
  localparam int EXPERT_W  = 8;
  localparam int TOK_W     = 16;
  localparam int GAIN_W    = 17;
  localparam int FUNC_W    = 3;
  localparam int CNT_W     = 48;
  localparam int SCORE_W   = 48;
  localparam int TSS_W     = 32;
  localparam int LAYERS_W  = 7;
  localparam int EXPERTS_W = 9;
  localparam int THR_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int GAIN_FRAC = 16;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 2;

  localparam logic [GAIN_W-1:0]    UNITY_Q16   = 17'd65536;
  localparam logic [LAYERS_W-1:0]  LAYERS_RST  = 7'd64;
  localparam logic [EXPERTS_W-1:0] EXPERTS_RST = 9'd256;
  localparam logic [THR_W-1:0]     THR_RST     = 24'd8192;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYERS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPERTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_RECORD = 3'd0,
    FN_TOKENS = 3'd1,
    FN_DECAY  = 3'd2,
    FN_FLUSH  = 3'd3,
    FN_QUERY  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POW,
    ST_SWEEP,
    ST_REREAD,
    ST_EXEC
  } state_t;

  // 0.999 raised to 2^k, in Q0.16.
  function automatic logic [15:0] pow_q16(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:    v = 16'd65470;
      4'd1:    v = 16'd65405;
      4'd2:    v = 16'd65274;
      4'd3:    v = 16'd65014;
      4'd4:    v = 16'd64495;
      4'd5:    v = 16'd63471;
      4'd6:    v = 16'd61471;
      4'd7:    v = 16'd57658;
      4'd8:    v = 16'd50728;
      4'd9:    v = 16'd39265;
      4'd10:   v = 16'd23526;
      4'd11:   v = 16'd8445;
      4'd12:   v = 16'd1088;
      4'd13:   v = 16'd18;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

### src/eudt_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module eudt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/eudt_pow.sv
// Square-and-multiply unit that forms 0.999^n in Q1.16, one bit of n per cycle.
`timescale 1ns / 1ps
module eudt_pow (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [eudt_pkg::TOK_W-1:0]   ntok,
  output logic                         done,
  output logic [eudt_pkg::GAIN_W-1:0]  factor
);
  import eudt_pkg::*;

  localparam int          PROD_W = GAIN_W + 16;
  localparam logic [3:0]  K_LAST = 4'(TOK_W - 1);
  localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (GAIN_FRAC - 1);

  logic              run_r;
  logic              done_r;
  logic [3:0]        k_r;
  logic [TOK_W-1:0]  bits_r;
  logic [GAIN_W-1:0] f_r;
  logic [PROD_W-1:0] prod;

  // Rounded product of the running factor and the table entry for this bit.
  assign prod = PROD_W'(f_r) * PROD_W'(pow_q16(k_r)) + ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (k_r == K_LAST)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r    <= '0;
      bits_r <= ntok;
      f_r    <= UNITY_Q16;
    end else if (run_r) begin
      k_r <= k_r + 4'd1;
      if (bits_r[k_r]) begin
        f_r <= prod[GAIN_FRAC +: GAIN_W];
      end
    end
  end

  assign done   = done_r;
  assign factor = f_r;

endmodule

### src/eudt_scale.sv
// Two-stage pipeline that scales a 48-bit score by a Q1.16 gain, truncating.
`timescale 1ns / 1ps
module eudt_scale #(
  parameter int AW = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [AW-1:0]                 in_addr,
  input  logic [eudt_pkg::SCORE_W-1:0]  in_score,
  input  logic [eudt_pkg::GAIN_W-1:0]   gain,
  output logic                          out_vld,
  output logic [AW-1:0]                 out_addr,
  output logic [eudt_pkg::SCORE_W-1:0]  out_score
);
  import eudt_pkg::*;

  localparam int HALF   = SCORE_W / 2;
  localparam int PROD_W = HALF + GAIN_W;
  localparam int SUM_W  = SCORE_W + GAIN_W;

  logic [PROD_W-1:0]  p_hi, p_lo;
  logic [PROD_W-1:0]  p_hi_r, p_lo_r;
  logic [AW-1:0]      a1_r, a2_r;
  logic               v1_r, v2_r;
  logic [SUM_W-1:0]   sum;
  logic [SCORE_W-1:0] score_r;

  // The score is split in halves so that each product stays narrow.
  assign p_hi = PROD_W'(in_score[SCORE_W-1:HALF]) * PROD_W'(gain);
  assign p_lo = PROD_W'(in_score[HALF-1:0]) * PROD_W'(gain);
  assign sum  = {p_hi_r, {HALF{1'b0}}} + SUM_W'(p_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_hi_r  <= p_hi;
    p_lo_r  <= p_lo;
    a1_r    <= in_addr;
    a2_r    <= a1_r;
    score_r <= sum[GAIN_FRAC +: SCORE_W];
  end

  assign out_vld   = v2_r;
  assign out_addr  = a2_r;
  assign out_score = score_r;

endmodule

### src/expert_usage_decay_tracker_core.sv
// Top level of the expert usage decay tracker: control sequencer and stores.
`timescale 1ns / 1ps
`include "expert_usage_decay_tracker_core_assert.svh"
// Keeps a saturating access count and a decaying Q32.16 score for every layer and
// expert, in two on-chip RAMs of MAX_LAYERS*MAX_EXPERTS entries (16384 by default).
// After reset a clearing pass writes zero to every entry, one per cycle, and the
// input is not ready until that pass is done; configuration writes are taken
// throughout. Record, query and flush requests read the entry when accepted and
// then, once the result register is free, modify, write back (record only) and
// register the result. A decay request sweeps the score RAM one entry per cycle
// through a two-stage multiply pipeline and then rereads the addressed entry.
// A tokens-generated request first forms 0.999^n, one bit of the token count per
// cycle, and then sweeps likewise. The result register lets a new request in
// while the previous result is still waiting to be taken.
module expert_usage_decay_tracker_core #(
  parameter int MAX_LAYERS      = 64,
  parameter int MAX_EXPERTS     = 256,
  parameter int SCORE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // layer_index, expert_index, token_count, decay_gain, zero pad
  input  logic [eudt_pkg::IN_DATA_W-1:0]    in_tdata,
  // func
  input  logic [eudt_pkg::FUNC_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // access_count, decayed_score
  output logic [eudt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // index_valid, sync_pulse
  output logic [eudt_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                              cfg_we,
  input  logic [eudt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eudt_pkg::THR_W-1:0]        cfg_wdata
);
  import eudt_pkg::*;

  localparam int ENTRIES = MAX_LAYERS * MAX_EXPERTS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0]      LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << SCORE_FRAC_BITS;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [TSS_W-1:0]   TSS_MAX   = '1;

  // Request fields.
  func_t               in_func;
  logic [LAYER_W-1:0]  in_layer;
  logic [EXPERT_W-1:0] in_expert;
  logic [TOK_W-1:0]    in_ntok;
  logic [GAIN_W-1:0]   in_gain;
  logic [GAIN_W-1:0]   gain_sat;
  logic                in_valid;
  logic [AW-1:0]       in_addr;

  assign in_func   = func_t'(in_tuser);
  assign in_layer  = in_tdata[5:0];
  assign in_expert = in_tdata[13:6];
  assign in_ntok   = in_tdata[29:14];
  assign in_gain   = in_tdata[46:30];
  assign gain_sat  = (in_gain > UNITY_Q16) ? UNITY_Q16 : in_gain;

  // Configuration registers.
  logic [LAYERS_W-1:0]  layers_r;
  logic [EXPERTS_W-1:0] experts_r;
  logic [THR_W-1:0]     thr_r;

  assign in_valid = (LAYERS_W'(in_layer) < layers_r) && (32'(in_layer) < MAX_LAYERS) &&
                    (EXPERTS_W'(in_expert) < experts_r) && (32'(in_expert) < MAX_EXPERTS);
  assign in_addr  = in_valid ? AW'(32'(in_layer) * MAX_EXPERTS + 32'(in_expert)) : '0;

  // Sequencer state.
  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              rd_done_r, rd_done_nxt;
  logic              sweep_rv_r;
  logic [AW-1:0]     sweep_ra_r;
  logic [GAIN_W-1:0] factor_r, factor_nxt;
  logic [TSS_W-1:0]  tss_r, tss_nxt;
  logic              dirty_r, dirty_nxt;

  // Latched request.
  func_t             req_func_r;
  logic              req_valid_r;
  logic [AW-1:0]     req_addr_r;
  logic [TOK_W-1:0]  req_ntok_r;
  logic              req_load;

  // Result register.
  logic               out_tvalid_r;
  logic [CNT_W-1:0]   out_count_r;
  logic [SCORE_W-1:0] out_score_r;
  logic               out_valid_r;
  logic               out_pulse_r;
  logic               out_load;
  logic [CNT_W-1:0]   res_count;
  logic [SCORE_W-1:0] res_score;
  logic               res_pulse;

  // RAM ports.
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               cnt_we, score_we;
  logic [CNT_W-1:0]   cnt_wdata, count_rd;
  logic [SCORE_W-1:0] score_wdata, score_rd;

  // Power unit and scaler.
  logic               pow_start, pow_done;
  logic [GAIN_W-1:0]  pow_factor;
  logic               sc_out_vld;
  logic [AW-1:0]      sc_out_addr;
  logic [SCORE_W-1:0] sc_out_score;

  // Read-modify-write arithmetic.
  logic [CNT_W-1:0]   count_inc;
  logic [SCORE_W:0]   score_sum;
  logic [SCORE_W-1:0] score_inc;
  logic [TSS_W:0]     tss_sum;
  logic [TSS_W-1:0]   tss_sat;
  logic               thr_hit;

  assign count_inc = (count_rd == CNT_MAX) ? CNT_MAX : count_rd + CNT_W'(1);
  assign score_sum = {1'b0, score_rd} + {1'b0, SCORE_ONE};
  assign score_inc = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
  assign tss_sum   = {1'b0, tss_r} + (TSS_W + 1)'(req_ntok_r);
  assign tss_sat   = tss_sum[TSS_W] ? TSS_MAX : tss_sum[TSS_W-1:0];
  assign thr_hit   = tss_sat >= TSS_W'(thr_r);

  eudt_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES), .AW(AW)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (wr_addr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (count_rd)
  );

  eudt_ram #(.WIDTH(SCORE_W), .DEPTH(ENTRIES), .AW(AW)) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (wr_addr),
    .wdata (score_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (score_rd)
  );

  eudt_pow u_pow (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (pow_start),
    .ntok   (in_ntok),
    .done   (pow_done),
    .factor (pow_factor)
  );

  eudt_scale #(.AW(AW)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (sweep_rv_r),
    .in_addr   (sweep_ra_r),
    .in_score  (score_rd),
    .gain      (factor_r),
    .out_vld   (sc_out_vld),
    .out_addr  (sc_out_addr),
    .out_score (sc_out_score)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rd_done_nxt = rd_done_r;
    factor_nxt  = factor_r;
    tss_nxt     = tss_r;
    dirty_nxt   = dirty_r;
    in_tready   = 1'b0;
    req_load    = 1'b0;
    pow_start   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = req_addr_r;
    wr_addr     = req_addr_r;
    cnt_we      = 1'b0;
    cnt_wdata   = '0;
    score_we    = 1'b0;
    score_wdata = '0;
    out_load    = 1'b0;
    res_count   = count_rd;
    res_score   = score_rd;
    res_pulse   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_we   = 1'b1;
        score_we = 1'b1;
        wr_addr  = cnt_r;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          req_load = 1'b1;
          rd_en    = 1'b1;
          rd_addr  = in_addr;
          unique case (in_func)
            FN_TOKENS: begin
              pow_start = 1'b1;
              state_nxt = ST_POW;
            end
            FN_DECAY: begin
              factor_nxt  = gain_sat;
              cnt_nxt     = '0;
              rd_done_nxt = 1'b0;
              state_nxt   = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_EXEC;
            end
          endcase
        end
      end
      ST_POW: begin
        if (pow_done) begin
          factor_nxt  = pow_factor;
          cnt_nxt     = '0;
          rd_done_nxt = 1'b0;
          state_nxt   = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!rd_done_r) begin
          rd_en   = 1'b1;
          rd_addr = cnt_r;
          if (cnt_r == LAST_ADDR) begin
            rd_done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
        // Writes trail the reads by the pipeline depth, so they never meet.
        score_we    = sc_out_vld;
        score_wdata = sc_out_score;
        wr_addr     = sc_out_addr;
        if (sc_out_vld && (sc_out_addr == LAST_ADDR)) begin
          state_nxt = ST_REREAD;
        end
      end
      ST_REREAD: begin
        rd_en     = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          unique case (req_func_r)
            FN_RECORD: begin
              if (req_valid_r) begin
                cnt_we      = 1'b1;
                score_we    = 1'b1;
                cnt_wdata   = count_inc;
                score_wdata = score_inc;
                res_count   = count_inc;
                res_score   = score_inc;
                dirty_nxt   = 1'b1;
              end
            end
            FN_TOKENS: begin
              if (thr_hit && dirty_r) begin
                res_pulse = 1'b1;
                dirty_nxt = 1'b0;
                tss_nxt   = '0;
              end else begin
                tss_nxt = tss_sat;
              end
            end
            FN_FLUSH: begin
              if (dirty_r) begin
                res_pulse = 1'b1;
                dirty_nxt = 1'b0;
                tss_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      rd_done_r    <= 1'b0;
      sweep_rv_r   <= 1'b0;
      tss_r        <= '0;
      dirty_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      layers_r     <= LAYERS_RST;
      experts_r    <= EXPERTS_RST;
      thr_r        <= THR_RST;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_done_r  <= rd_done_nxt;
      sweep_rv_r <= (state_r == ST_SWEEP) && !rd_done_r;
      tss_r      <= tss_nxt;
      dirty_r    <= dirty_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LAYERS:  layers_r  <= cfg_wdata[LAYERS_W-1:0];
          CFG_EXPERTS: experts_r <= cfg_wdata[EXPERTS_W-1:0];
          CFG_THRESH:  thr_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    factor_r   <= factor_nxt;
    sweep_ra_r <= cnt_r;
    if (req_load) begin
      req_func_r  <= in_func;
      req_valid_r <= in_valid;
      req_addr_r  <= in_addr;
      req_ntok_r  <= in_ntok;
    end
    if (out_load) begin
      out_count_r <= req_valid_r ? res_count : '0;
      out_score_r <= req_valid_r ? res_score : '0;
      out_valid_r <= req_valid_r;
      out_pulse_r <= res_pulse;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_score_r, out_count_r};
  assign out_tuser  = {out_pulse_r, out_valid_r};

  `EUDT_ASSERT_IMP(a_scale_only_in_sweep, sc_out_vld, state_r == ST_SWEEP)
  `EUDT_ASSERT_IMP(a_write_trails_read, (sc_out_vld && !rd_done_r), (sc_out_addr < cnt_r))
  `EUDT_ASSERT_IMP(a_count_write_on_record, (state_r == ST_EXEC && cnt_we), (req_func_r == FN_RECORD && req_valid_r))
  `EUDT_ASSERT_IMP(a_pulse_source, (out_load && res_pulse), (req_func_r == FN_TOKENS || req_func_r == FN_FLUSH))
  `EUDT_ASSERT_NXT(a_pulse_clears_sync, (out_load && res_pulse), (!dirty_r && tss_r == '0))

endmodule
